>>> sv/mru_page_frame_replacer_macros.svh
// Assertion macros used by the page frame replacer sequencer.
`ifndef MRU_PAGE_FRAME_REPLACER_MACROS_SVH
`define MRU_PAGE_FRAME_REPLACER_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define MPFR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define MPFR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mpfr_pkg.sv
// Shared constants and types of the page frame replacer.
package mpfr_pkg;
	localparam int FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;
	localparam int IDX_OUT_W = 4;
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef struct packed {
		logic valid;
		logic hit;
		logic empty;
	} scan_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} ctrl_state_t;
endpackage

>>> sv/mpfr_cell.sv
// One frame cell: holds a frame and passes the lookup beat on to the next cell.
module mpfr_cell #(
	parameter int FRAMES = mpfr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = mpfr_pkg::PAGE_BITS_DEF,
	parameter int K = 0,
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int NW = $clog2(FRAMES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [NW-1:0]           n_active,
	input  logic [IW-1:0]           victim_idx,
	input  logic                    wr_en,
	input  logic [IW-1:0]           wr_idx,
	input  logic [PAGE_BITS-1:0]    wr_page,
	input  mpfr_pkg::scan_flags_t   in_flags,
	input  logic [PAGE_BITS-1:0]    in_page,
	input  logic [IW-1:0]           in_hidx,
	input  logic [IW-1:0]           in_eidx,
	input  logic [PAGE_BITS-1:0]    in_vpage,
	output mpfr_pkg::scan_flags_t   out_flags,
	output logic [PAGE_BITS-1:0]    out_page,
	output logic [IW-1:0]           out_hidx,
	output logic [IW-1:0]           out_eidx,
	output logic [PAGE_BITS-1:0]    out_vpage
);
	import mpfr_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(K);
	localparam logic [NW-1:0] MY_NUM = NW'(K);

	logic                 valid_q;
	logic [PAGE_BITS-1:0] frame_q;
	scan_flags_t          flags_q;
	logic [PAGE_BITS-1:0] req_q;
	logic [IW-1:0]        hidx_q;
	logic [IW-1:0]        eidx_q;
	logic [PAGE_BITS-1:0] vpage_q;

	logic        active;
	logic        hit_here;
	logic        empty_here;
	scan_flags_t flags_d;

	assign active = (MY_NUM < n_active);
	assign hit_here = active && valid_q && (frame_q == in_page) && !in_flags.hit;
	assign empty_here = active && !valid_q && !in_flags.empty;

	always_comb begin
		flags_d.valid = in_flags.valid;
		flags_d.hit = in_flags.hit || hit_here;
		flags_d.empty = in_flags.empty || empty_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
			if (wr_en && (wr_idx == MY_IDX)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == MY_IDX)) begin
			frame_q <= wr_page;
		end
		req_q <= in_page;
		hidx_q <= hit_here ? MY_IDX : in_hidx;
		eidx_q <= empty_here ? MY_IDX : in_eidx;
		vpage_q <= (victim_idx == MY_IDX) ? frame_q : in_vpage;
	end

	assign out_flags = flags_q;
	assign out_page = req_q;
	assign out_hidx = hidx_q;
	assign out_eidx = eidx_q;
	assign out_vpage = vpage_q;
endmodule

>>> sv/mpfr_ctrl.sv
// Request sequencer: launches lookups into the cell chain, updates the table and the result.
`include "mru_page_frame_replacer_macros.svh"

module mpfr_ctrl #(
	parameter int FRAMES = mpfr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = mpfr_pkg::PAGE_BITS_DEF,
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int NW = $clog2(FRAMES + 1),
	localparam int OUT_W = ((PAGE_BITS + 38 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [NW-1:0]         n_active,
	output logic [IW-1:0]         victim_idx,
	output mpfr_pkg::scan_flags_t head_flags,
	input  mpfr_pkg::scan_flags_t tail_flags,
	input  logic [PAGE_BITS-1:0]  tail_page,
	input  logic [IW-1:0]         tail_hidx,
	input  logic [IW-1:0]         tail_eidx,
	input  logic [PAGE_BITS-1:0]  tail_vpage,
	output logic                  wr_en,
	output logic [IW-1:0]         wr_idx,
	output logic [PAGE_BITS-1:0]  wr_page,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata
);
	import mpfr_pkg::*;

	localparam int PAD_W = OUT_W - (PAGE_BITS + 38);

	ctrl_state_t          state_q;
	ctrl_state_t          state_d;
	logic [IW-1:0]        last_frame_q;
	logic [31:0]          fault_count_q;
	logic                 res_hit_q;
	logic                 res_empty_q;
	logic [PAGE_BITS-1:0] res_page_q;
	logic [IW-1:0]        res_hidx_q;
	logic [IW-1:0]        res_eidx_q;
	logic [PAGE_BITS-1:0] res_vpage_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_data_q;

	logic                 accept;
	logic                 ld;
	logic [IW-1:0]        slot;
	logic                 evict;
	logic [PAGE_BITS-1:0] old_page;
	logic [31:0]          fault_next;
	logic [IW+3:0]        slot_ext;

	assign victim_idx = (NW'(last_frame_q) < n_active) ? last_frame_q : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SCAN;
			ST_SCAN:  if (tail_flags.valid) state_d = ST_WRITE;
			ST_WRITE: if (ld) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		ld = (state_q == ST_WRITE) && (!m_tvalid_q || m_tready);
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		head_flags.valid = accept;
		head_flags.hit = 1'b0;
		head_flags.empty = 1'b0;
	end

	always_comb begin
		evict = 1'b0;
		old_page = '0;
		if (res_hit_q) begin
			slot = res_hidx_q;
		end else if (res_empty_q) begin
			slot = res_eidx_q;
		end else begin
			slot = victim_idx;
			evict = 1'b1;
			old_page = res_vpage_q;
		end
		if (res_hit_q || (fault_count_q == '1)) begin
			fault_next = fault_count_q;
		end else begin
			fault_next = fault_count_q + 32'd1;
		end
		slot_ext = {4'b0, slot};
	end

	assign wr_en = ld && !res_hit_q;
	assign wr_idx = slot;
	assign wr_page = res_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_frame_q <= '0;
			fault_count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				last_frame_q <= slot;
				fault_count_q <= fault_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_flags.valid) begin
			res_hit_q <= tail_flags.hit;
			res_empty_q <= tail_flags.empty;
			res_page_q <= tail_page;
			res_hidx_q <= tail_hidx;
			res_eidx_q <= tail_eidx;
			res_vpage_q <= tail_vpage;
		end
		if (ld) begin
			m_data_q <= {{PAD_W{1'b0}}, fault_next, old_page, evict,
				slot_ext[IDX_OUT_W-1:0], !res_hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_data_q;

	`MPFR_ASSERT_NEXT(a_one_in_flight, clk, arst_n, accept, !s_tready, "second beat accepted during a lookup")
	`MPFR_ASSERT_NOW(a_tail_in_scan, clk, arst_n, tail_flags.valid, state_q == ST_SCAN, "lookup left the chain outside the scan state")
	`MPFR_ASSERT_NEXT(a_hit_no_fault, clk, arst_n, ld && res_hit_q, fault_count_q == $past(fault_count_q), "fault counted on a hit")
	`MPFR_ASSERT_NOW(a_victim_active, clk, arst_n, n_active != '0, NW'(victim_idx) < n_active, "victim frame outside the active range")
endmodule

>>> sv/mru_page_frame_replacer.sv
// Top level of the page frame replacer: configuration port, frame cell chain and sequencer.
// Each request beat walks the chain of FRAMES frame cells, one cell per cycle, collecting the
// lowest matching frame, the lowest empty frame and the page of the most recently used frame;
// the table is then updated and the result beat loaded when no earlier result beat waits on
// m_tready, and no new request beat is accepted until then. A hit returns its frame; a miss
// fills the lowest empty active frame, or else evicts the frame used by the previous request
// (frame 0 if that frame is no longer active). Only frames below frames_in_use (0 read as 1,
// clamped to FRAMES) take part. The fault total saturates. All frames are empty after reset.
module mru_page_frame_replacer #(
	parameter int FRAMES = mpfr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = mpfr_pkg::PAGE_BITS_DEF,
	localparam int IN_W = ((PAGE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((PAGE_BITS + 38 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             s_tvalid,
	output logic             s_tready,
	// Fields from bit 0: page_number.
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// Fields from bit 0: page_fault, frame_index, replaced, evicted_page, fault_total.
	output logic [OUT_W-1:0] m_tdata
);
	import mpfr_pkg::*;

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);

	logic [CFG_W-1:0] frames_in_use_q;
	logic             reg_idx;
	logic [NW-1:0]    n_active;
	logic [IW-1:0]    victim_idx;
	logic             wr_en;
	logic [IW-1:0]    wr_idx;
	logic [PAGE_BITS-1:0] wr_page;

	scan_flags_t          ch_flags [FRAMES+1];
	logic [PAGE_BITS-1:0] ch_page  [FRAMES+1];
	logic [IW-1:0]        ch_hidx  [FRAMES+1];
	logic [IW-1:0]        ch_eidx  [FRAMES+1];
	logic [PAGE_BITS-1:0] ch_vpage [FRAMES+1];

	assign pready = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_IN_USE_RST;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_FRAMES_IN_USE)) begin
			frames_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAMES_IN_USE: prdata = {{(32-CFG_W){1'b0}}, frames_in_use_q};
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		if (frames_in_use_q == '0) begin
			n_active = NW'(1);
		end else if (32'(frames_in_use_q) > 32'(FRAMES)) begin
			n_active = NW'(FRAMES);
		end else begin
			n_active = NW'(frames_in_use_q);
		end
	end

	assign ch_page[0] = s_tdata[PAGE_BITS-1:0];
	assign ch_hidx[0] = '0;
	assign ch_eidx[0] = '0;
	assign ch_vpage[0] = '0;

	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		mpfr_cell #(
			.FRAMES   (FRAMES),
			.PAGE_BITS(PAGE_BITS),
			.K        (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.n_active  (n_active),
			.victim_idx(victim_idx),
			.wr_en     (wr_en),
			.wr_idx    (wr_idx),
			.wr_page   (wr_page),
			.in_flags  (ch_flags[k]),
			.in_page   (ch_page[k]),
			.in_hidx   (ch_hidx[k]),
			.in_eidx   (ch_eidx[k]),
			.in_vpage  (ch_vpage[k]),
			.out_flags (ch_flags[k+1]),
			.out_page  (ch_page[k+1]),
			.out_hidx  (ch_hidx[k+1]),
			.out_eidx  (ch_eidx[k+1]),
			.out_vpage (ch_vpage[k+1])
		);
	end

	mpfr_ctrl #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.n_active  (n_active),
		.victim_idx(victim_idx),
		.head_flags(ch_flags[0]),
		.tail_flags(ch_flags[FRAMES]),
		.tail_page (ch_page[FRAMES]),
		.tail_hidx (ch_hidx[FRAMES]),
		.tail_eidx (ch_eidx[FRAMES]),
		.tail_vpage(ch_vpage[FRAMES]),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_page   (wr_page),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);
endmodule
